FILE: hw/rtl/gtmac_pkg.sv
// Shared types and constants for the 4x4 outer-product MAC tile.
// No dependencies; used by every module of the block.
package gtmac_pkg;

  localparam int TILE  = 4;
  localparam int ROW_W = 2;

  typedef logic [ROW_W-1:0] row_idx_t;

  typedef struct packed {
    logic vld;
    logic last;
  } step_ctl_t;

endpackage

FILE: hw/rtl/gtmac_mac_array.sv
// 16-lane MAC array: product register stage, then saturating accumulators.
// Depends on gtmac_pkg (TILE, step_ctl_t).
module gtmac_mac_array #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  gtmac_pkg::step_ctl_t         ctl_i,
  input  logic signed [DATA_WIDTH-1:0] a_i [gtmac_pkg::TILE],
  input  logic signed [DATA_WIDTH-1:0] b_i [gtmac_pkg::TILE],
  output gtmac_pkg::step_ctl_t         ctl_o,
  output logic signed [ACC_WIDTH-1:0]  sum_o [gtmac_pkg::TILE*gtmac_pkg::TILE]
);

  localparam int NACC = gtmac_pkg::TILE * gtmac_pkg::TILE;
  localparam int PW   = 2 * DATA_WIDTH;
  localparam int SW   = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
  localparam int HW   = SW - ACC_WIDTH + 1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  gtmac_pkg::step_ctl_t        ctl_r;
  logic signed [PW-1:0]        prod_r   [NACC];
  logic signed [PW-1:0]        prod_nxt [NACC];
  logic signed [ACC_WIDTH-1:0] acc_r    [NACC];
  logic signed [ACC_WIDTH-1:0] acc_nxt  [NACC];

  always_comb begin
    for (int i = 0; i < gtmac_pkg::TILE; i++) begin
      for (int j = 0; j < gtmac_pkg::TILE; j++) begin
        prod_nxt[i*gtmac_pkg::TILE+j] = PW'(a_i[i]) * PW'(b_i[j]);
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    s = '0;
    for (int k = 0; k < NACC; k++) begin
      s = SW'(acc_r[k]) + SW'(prod_r[k]);
      if (s[SW-1:ACC_WIDTH-1] == {HW{1'b0}} || s[SW-1:ACC_WIDTH-1] == {HW{1'b1}}) begin
        acc_nxt[k] = s[ACC_WIDTH-1:0];
      end else if (s[SW-1]) begin
        acc_nxt[k] = ACC_MIN;
      end else begin
        acc_nxt[k] = ACC_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NACC; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      for (int k = 0; k < NACC; k++) begin
        acc_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r <= ctl_i;
      if (ctl_r.vld) begin
        for (int k = 0; k < NACC; k++) begin
          acc_r[k] <= ctl_r.last ? '0 : acc_nxt[k];
        end
      end
    end
  end

  assign ctl_o = ctl_r;
  assign sum_o = acc_nxt;

endmodule

FILE: hw/rtl/gtmac_drain.sv
// Tile row buffer: captures a finished tile and hands it out one row per word.
// Depends on gtmac_pkg (TILE, row_idx_t).
module gtmac_drain #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic signed [ACC_WIDTH-1:0] sum_i [gtmac_pkg::TILE*gtmac_pkg::TILE],
  input  logic                        out_ready,
  output logic                        busy,
  output gtmac_pkg::row_idx_t         row_idx,
  output logic                        row_last,
  output logic signed [ACC_WIDTH-1:0] row_o [gtmac_pkg::TILE]
);

  localparam int T = gtmac_pkg::TILE;

  logic signed [ACC_WIDTH-1:0] rows_r [T*T];
  gtmac_pkg::row_idx_t         cnt_r;
  logic                        busy_r;
  logic                        take;

  assign take     = busy_r && out_ready;
  assign row_last = (cnt_r == gtmac_pkg::row_idx_t'(T - 1));

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < T*T; k++) begin
        rows_r[k] <= sum_i[k];
      end
    end else if (take) begin
      for (int k = 0; k < T*(T-1); k++) begin
        rows_r[k] <= rows_r[k+T];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      if (row_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < T; j++) begin
      row_o[j] = rows_r[j];
    end
  end

  assign busy    = busy_r;
  assign row_idx = cnt_r;

endmodule

FILE: hw/rtl/gemm_tile_4x4_outer_product_mac_unit.sv
// 4x4 outer-product MAC tile, top level: input register, MAC array, row buffer.
// A step flagged last passes the input and product registers, then its sums load
// the row buffer: row 0 shows, rows 1..3 follow one per cycle as out_ready allows.
// Throughput: one step per cycle; a last step waits in the accumulate stage
// only while the previous tile's four rows are still being handed out.
// Reset (rst_n, synchronous): clears valid flags, row buffer busy flag and row count, and accumulators.
module gemm_tile_4x4_outer_product_mac_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_a_row0,
  input  logic signed [DATA_WIDTH-1:0] in_a_row1,
  input  logic signed [DATA_WIDTH-1:0] in_a_row2,
  input  logic signed [DATA_WIDTH-1:0] in_a_row3,
  input  logic signed [DATA_WIDTH-1:0] in_b_col0,
  input  logic signed [DATA_WIDTH-1:0] in_b_col1,
  input  logic signed [DATA_WIDTH-1:0] in_b_col2,
  input  logic signed [DATA_WIDTH-1:0] in_b_col3,
  input  logic                         in_last_step,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_row_index,
  output logic signed [ACC_WIDTH-1:0]  out_sum_col0,
  output logic signed [ACC_WIDTH-1:0]  out_sum_col1,
  output logic signed [ACC_WIDTH-1:0]  out_sum_col2,
  output logic signed [ACC_WIDTH-1:0]  out_sum_col3,
  output logic                         out_tile_done
);

  localparam int T = gtmac_pkg::TILE;

  logic signed [DATA_WIDTH-1:0] a_r [T];
  logic signed [DATA_WIDTH-1:0] b_r [T];
  gtmac_pkg::step_ctl_t         ctl1_r;
  gtmac_pkg::step_ctl_t         ctl1_nxt;
  gtmac_pkg::step_ctl_t         ctl2;
  logic signed [ACC_WIDTH-1:0]  sums [T*T];
  logic signed [ACC_WIDTH-1:0]  row  [T];
  logic                         busy;
  logic                         adv;
  logic                         load;

  // hold the pipe while a finished tile cannot enter the busy row buffer
  assign adv      = !(ctl2.vld && ctl2.last && busy);
  assign load     = adv && ctl2.vld && ctl2.last;
  assign in_ready = adv;

  assign ctl1_nxt.vld  = in_valid;
  assign ctl1_nxt.last = in_last_step;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= in_a_row0;
      a_r[1] <= in_a_row1;
      a_r[2] <= in_a_row2;
      a_r[3] <= in_a_row3;
      b_r[0] <= in_b_col0;
      b_r[1] <= in_b_col1;
      b_r[2] <= in_b_col2;
      b_r[3] <= in_b_col3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  gtmac_mac_array #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl1_r),
    .a_i   (a_r),
    .b_i   (b_r),
    .ctl_o (ctl2),
    .sum_o (sums)
  );

  gtmac_drain #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .sum_i     (sums),
    .out_ready (out_ready),
    .busy      (busy),
    .row_idx   (out_row_index),
    .row_last  (out_tile_done),
    .row_o     (row)
  );

  assign out_valid    = busy;
  assign out_sum_col0 = row[0];
  assign out_sum_col1 = row[1];
  assign out_sum_col2 = row[2];
  assign out_sum_col3 = row[3];

endmodule
